@@ rtl/core/ewh_pkg.sv @@
package ewh_pkg;

	localparam int ONE_Q8 = 256;

	typedef struct packed {
		logic load;
		logic range;
		logic read;
		logic mul;
		logic div_start;
		logic acc;
		logic emit;
		logic emit_adv;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_sample;
		logic last_bin;
	} stat_t;

endpackage

@@ rtl/core/equal_width_histogram.sv @@
// Channel  Direction  tdata (low bit up)                                  tuser    tlast
// s_*      in         sample                                              -        final_sample
// m_*      out        bin_index, bin_count, peak_count, range_low/high    dropped  final_bin
//
// Samples are taken one word per cycle while the block loads a set.
// After the last sample the binning pass reads the sample store once per
// stored sample; each read runs through the multiply, bit-per-cycle divide
// and accumulate steps. Input is held off until the BINS result words of
// the set have left, one per cycle while m_tready is high.
// Reset is asynchronous, active low, and needs no clearing pass.
module equal_width_histogram #(
	parameter int MAX_SAMPLES = 1024,
	parameter int BINS        = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// bin_index, bin_count, peak_count, range_low, range_high
	output logic [(($clog2(BINS)+2*$clog2(MAX_SAMPLES+1)+2*(SAMPLE_BITS+1)+7)/8)*8-1:0] m_tdata,
	output logic                 m_tuser, // dropped
	output logic                 m_tlast
);

	localparam int IW    = $clog2(BINS);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int RW    = SAMPLE_BITS + 1;
	localparam int OFW   = IW + 2 * CW + 2 * RW;
	localparam int OW    = ((OFW + 7) / 8) * 8;

	ewh_pkg::cmd_t  cmd;
	ewh_pkg::stat_t stat;

	logic [IW-1:0] bin_index;
	logic [CW-1:0] bin_count;
	logic [CW-1:0] peak_count;
	logic [RW-1:0] range_low;
	logic [RW-1:0] range_high;
	logic          dropped;

	ewh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ewh_dp #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.BINS       (BINS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.bin_index (bin_index),
		.bin_count (bin_count),
		.peak_count(peak_count),
		.range_low (range_low),
		.range_high(range_high),
		.dropped   (dropped)
	);

	assign m_tdata = OW'({range_high, range_low, peak_count, bin_count, bin_index});
	assign m_tuser = dropped;
	assign m_tlast = stat.last_bin;

endmodule

@@ rtl/core/ewh_div.sv @@
module ewh_div #(
	parameter int DW = 18,
	parameter int QW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int WW = DW + QW;
	localparam int CNTW = $clog2(QW);

	logic [WW-1:0]   rem_q;
	logic [WW-1:0]   dv_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            fit;

	assign fit = (rem_q >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dv_q  <= WW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= rem_q - dv_q;
			end
			quo_q <= {quo_q[QW-2:0], fit};
			dv_q  <= dv_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/core/ewh_dp.sv @@
module ewh_dp #(
	parameter int MAX_SAMPLES = 1024,
	parameter int BINS        = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ewh_pkg::cmd_t                  cmd,
	output ewh_pkg::stat_t                 stat,
	input  logic [SAMPLE_BITS-1:0]         sample,
	output logic [$clog2(BINS)-1:0]        bin_index,
	output logic [$clog2(MAX_SAMPLES+1)-1:0] bin_count,
	output logic [$clog2(MAX_SAMPLES+1)-1:0] peak_count,
	output logic [SAMPLE_BITS:0]           range_low,
	output logic [SAMPLE_BITS:0]           range_high,
	output logic                           dropped
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = $clog2(BINS);
	localparam int QW = $clog2(BINS + 1);
	localparam int DW = SB + 2;
	localparam int WW = DW + QW;

	logic [SB-1:0] mem [MAX_SAMPLES];

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic                 ovf_q;
	logic [CW-1:0]        bins_q [BINS];
	logic [CW-1:0]        peak_q;
	logic [IW-1:0]        oidx_q;
	logic signed [DW-1:0] lo_q;
	logic signed [DW-1:0] hi_q;
	logic [SB-1:0]        rd_q;
	logic [WW-1:0]        prod_q;

	logic                 full;
	logic                 store;
	logic signed [SB-1:0] s_val;
	logic signed [DW-1:0] lo_w;
	logic signed [DW-1:0] hi_w;
	logic signed [DW-1:0] diff;
	logic [DW-1:0]        d_w;
	logic [DW-1:0]        span;
	logic                 div_done;
	logic [QW-1:0]        quo;
	logic [IW-1:0]        qbin;
	logic [IW-1:0]        sel;
	logic [CW-1:0]        bins_rd;
	logic [CW-1:0]        bins_inc;

	assign full  = (count_q == CW'(MAX_SAMPLES));
	assign store = cmd.load && !full;
	assign s_val = sample;

	always_comb begin
		lo_w = {{2{min_q[SB-1]}}, min_q};
		hi_w = {{2{max_q[SB-1]}}, max_q};
		if (min_q == max_q) begin
			lo_w = lo_w - DW'(ewh_pkg::ONE_Q8);
			hi_w = hi_w + DW'(ewh_pkg::ONE_Q8);
		end
	end

	assign diff = $signed({{2{rd_q[SB-1]}}, rd_q}) - lo_q;
	assign d_w  = diff[DW-1] ? '0 : diff;
	assign span = hi_q - lo_q;

	ewh_div #(
		.DW(DW),
		.QW(QW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod_q),
		.den   (span),
		.done  (div_done),
		.quo   (quo)
	);

	assign qbin     = (quo >= QW'(BINS)) ? IW'(BINS - 1) : quo[IW-1:0];
	assign sel      = cmd.emit ? oidx_q : qbin;
	assign bins_rd  = bins_q[sel];
	assign bins_inc = bins_rd + 1'b1;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[AW-1:0]] <= sample;
		end
		if (cmd.read) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
		if (cmd.range) begin
			lo_q <= lo_w;
			hi_q <= hi_w;
		end
		if (cmd.mul) begin
			prod_q <= WW'(d_w) * WW'(BINS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			ovf_q   <= 1'b0;
			peak_q  <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			count_q <= '0;
			idx_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			ovf_q   <= 1'b0;
			peak_q  <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					if (count_q == '0 || s_val < min_q) begin
						min_q <= s_val;
					end
					if (count_q == '0 || s_val > max_q) begin
						max_q <= s_val;
					end
				end
			end
			if (cmd.acc) begin
				bins_q[qbin] <= bins_inc;
				idx_q        <= idx_q + 1'b1;
				if (bins_inc > peak_q) begin
					peak_q <= bins_inc;
				end
			end
			if (cmd.emit_adv) begin
				oidx_q <= oidx_q + 1'b1;
			end
		end
	end

	assign stat.div_done    = div_done;
	assign stat.last_sample = (idx_q == count_q - 1'b1);
	assign stat.last_bin    = (oidx_q == IW'(BINS - 1));

	assign bin_index  = oidx_q;
	assign bin_count  = bins_rd;
	assign peak_count = peak_q;
	assign range_low  = lo_q[SB:0];
	assign range_high = hi_q[SB:0];
	assign dropped    = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> peak_q >= bins_rd)
		else $error("peak below a bin count");

	a_span_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> hi_q > lo_q)
		else $error("empty binning range");

	a_acc_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> idx_q < count_q)
		else $error("binning past stored samples");

endmodule

@@ rtl/core/ewh_ctrl.sv @@
module ewh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_tlast,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  ewh_pkg::stat_t stat,
	output ewh_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_RANGE;
				end
			end
			ST_RANGE: begin
				cmd.range = 1'b1;
				state_d   = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last_sample ? ST_EMIT : ST_READ;
			end
			ST_EMIT: begin
				cmd.emit     = 1'b1;
				cmd.emit_adv = m_tready;
				if (m_tready && stat.last_bin) begin
					cmd.clear = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_EMIT);

	a_sides_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

endmodule
